FILE: design/glyph_color_expander_core_macros.svh
// Assertion macros for the glyph color expander, used by gce_back.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef GLYPH_COLOR_EXPANDER_CORE_MACROS_SVH
`define GLYPH_COLOR_EXPANDER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GCE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define GCE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/gce_pkg.sv
// Package of the glyph color expander: register map, depth modes, queue entry type.
// Used by every module of the block; depends on nothing.
package gce_pkg;

	localparam int MAX_GLYPH_WIDTH  = 32;
	localparam int MAX_GLYPH_HEIGHT = 64;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	localparam logic [2:0] REG_DEPTH_MODE   = 3'd0;
	localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd1;
	localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd2;
	localparam logic [2:0] REG_INK_COLOR    = 3'd3;
	localparam logic [2:0] REG_PAPER_COLOR  = 3'd4;

	localparam logic [3:0] PAIRS_PER_BYTE = 4'd4;
	localparam logic [3:0] BITS_PER_BYTE  = 4'd8;

	typedef enum logic [1:0] {
		DEPTH_4BPP  = 2'd0,
		DEPTH_8BPP  = 2'd1,
		DEPTH_16BPP = 2'd2,
		DEPTH_32BPP = 2'd3
	} depth_mode_t;

	typedef struct packed {
		depth_mode_t depth_mode;
		logic [5:0]  eff_width;
		logic [6:0]  eff_height;
		logic [31:0] ink_color;
		logic [31:0] paper_color;
		logic        clear;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data;
		logic [3:0] count;
		logic       ends_row;
		logic       ends_glyph;
	} job_t;

endpackage

FILE: design/glyph_color_expander_core.sv
// Top level of the glyph color expander: register file, front part, queue and back part.
// Depends on gce_pkg, gce_regs, gce_front, gce_fifo and gce_back.
//
// Channel    Handshake                  Payload
// config     psel/penable/pwrite/pready paddr, pwdata, prdata
// bytes in   byte_valid / byte_stall    glyph_byte
// words out  pixel_valid / pixel_stall  pixel_word, last_of_byte, row_end, glyph_end
//
// The back part sends one word per cycle unless pixel_stall holds the output; a byte gives four words at 4 bpp and
// one to eight words (the row bits it covers) in the other modes.
// A four-entry queue lets bytes enter while earlier ones are still being expanded.
// Reset restores the register defaults, clears the row and glyph position and empties the queue.
// pixel_stall holds the output register; byte_stall rises only when the queue is full.
module glyph_color_expander_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gce_pkg::ADDR_W-1:0] paddr,
	input  logic [gce_pkg::DATA_W-1:0] pwdata,
	output logic [gce_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	input  logic                       byte_valid,
	output logic                       byte_stall,
	input  logic [7:0]                 glyph_byte,
	output logic                       pixel_valid,
	input  logic                       pixel_stall,
	output logic [31:0]                pixel_word,
	output logic                       last_of_byte,
	output logic                       row_end,
	output logic                       glyph_end
);

	gce_pkg::cfg_t cfg;
	gce_pkg::job_t push_job;
	gce_pkg::job_t head;
	logic          push;
	logic          pop;
	logic          full;
	logic          empty;

	gce_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.byte_valid (byte_valid),
		.glyph_byte (glyph_byte),
		.queue_full (full),
		.byte_stall (byte_stall),
		.push       (push),
		.push_job   (push_job)
	);

	gce_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	gce_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_word   (pixel_word),
		.last_of_byte (last_of_byte),
		.row_end      (row_end),
		.glyph_end    (glyph_end)
	);

endmodule

FILE: design/gce_regs.sv
// Configuration register file of the glyph color expander with its APB-style port.
// Depends on gce_pkg; feeds the front and back parts through gce_pkg::cfg_t.
module gce_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gce_pkg::ADDR_W-1:0]  paddr,
	input  logic [gce_pkg::DATA_W-1:0]  pwdata,
	output logic [gce_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output gce_pkg::cfg_t               cfg
);

	logic [1:0]  depth_mode_q;
	logic [5:0]  width_q;
	logic [6:0]  height_q;
	logic [31:0] ink_color_q;
	logic [31:0] paper_color_q;
	logic [2:0]  index;
	logic        wr_en;
	logic        wr_hit;

	assign pready = 1'b1;
	assign index  = paddr[4:2];
	assign wr_en  = psel && penable && pwrite && pready;
	assign wr_hit = wr_en && (index <= gce_pkg::REG_PAPER_COLOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_mode_q  <= 2'd1;
			width_q       <= 6'd8;
			height_q      <= 7'd16;
			ink_color_q   <= 32'h00FF_FFFF;
			paper_color_q <= 32'h0000_0000;
		end else if (wr_en) begin
			unique case (index)
				gce_pkg::REG_DEPTH_MODE:   depth_mode_q  <= pwdata[1:0];
				gce_pkg::REG_GLYPH_WIDTH:  width_q       <= pwdata[5:0];
				gce_pkg::REG_GLYPH_HEIGHT: height_q      <= pwdata[6:0];
				gce_pkg::REG_INK_COLOR:    ink_color_q   <= pwdata;
				gce_pkg::REG_PAPER_COLOR:  paper_color_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (index)
			gce_pkg::REG_DEPTH_MODE:   prdata = {30'd0, depth_mode_q};
			gce_pkg::REG_GLYPH_WIDTH:  prdata = {26'd0, width_q};
			gce_pkg::REG_GLYPH_HEIGHT: prdata = {25'd0, height_q};
			gce_pkg::REG_INK_COLOR:    prdata = ink_color_q;
			gce_pkg::REG_PAPER_COLOR:  prdata = paper_color_q;
			default:                   prdata = '0;
		endcase
	end

	always_comb begin
		cfg.depth_mode = gce_pkg::depth_mode_t'(depth_mode_q);
		priority if (width_q == 6'd0)
			cfg.eff_width = 6'd1;
		else if (width_q > 6'(gce_pkg::MAX_GLYPH_WIDTH))
			cfg.eff_width = 6'(gce_pkg::MAX_GLYPH_WIDTH);
		else
			cfg.eff_width = width_q;
		priority if (height_q == 7'd0)
			cfg.eff_height = 7'd1;
		else if (height_q > 7'(gce_pkg::MAX_GLYPH_HEIGHT))
			cfg.eff_height = 7'(gce_pkg::MAX_GLYPH_HEIGHT);
		else
			cfg.eff_height = height_q;
		cfg.ink_color   = ink_color_q;
		cfg.paper_color = paper_color_q;
		cfg.clear       = wr_hit;
	end

endmodule

FILE: design/gce_front.sv
// Front part of the glyph color expander: accepts bitmap bytes and tracks row and glyph position.
// Depends on gce_pkg; pushes one gce_pkg::job_t per byte into the queue.
module gce_front (
	input  logic          clk,
	input  logic          arst_n,
	input  gce_pkg::cfg_t cfg,
	input  logic          byte_valid,
	input  logic [7:0]    glyph_byte,
	input  logic          queue_full,
	output logic          byte_stall,
	output logic          push,
	output gce_pkg::job_t push_job
);

	// A stored bit count of zero stands for a fresh row of the full glyph width.
	logic [5:0] bits_left_q;
	logic [6:0] row_index_q;
	logic [5:0] left_eff;
	logic [3:0] nbits;
	logic [5:0] remain;
	logic [6:0] row_next;
	logic       ends_row;
	logic       ends_glyph;

	assign byte_stall = queue_full;
	assign push       = byte_valid && !byte_stall;

	always_comb begin
		if (bits_left_q == 6'd0 || bits_left_q > cfg.eff_width)
			left_eff = cfg.eff_width;
		else
			left_eff = bits_left_q;
		nbits      = (left_eff < 6'd8) ? left_eff[3:0] : gce_pkg::BITS_PER_BYTE;
		remain     = left_eff - {2'd0, nbits};
		ends_row   = (remain == 6'd0);
		row_next   = row_index_q + 7'd1;
		ends_glyph = ends_row && (row_next >= cfg.eff_height);
	end

	always_comb begin
		push_job.data       = glyph_byte;
		push_job.count      = (cfg.depth_mode == gce_pkg::DEPTH_4BPP) ?
		                      gce_pkg::PAIRS_PER_BYTE : nbits;
		push_job.ends_row   = ends_row;
		push_job.ends_glyph = ends_glyph;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_left_q <= 6'd0;
			row_index_q <= 7'd0;
		end else if (cfg.clear) begin
			bits_left_q <= 6'd0;
			row_index_q <= 7'd0;
		end else if (push) begin
			bits_left_q <= remain;
			if (ends_glyph)
				row_index_q <= 7'd0;
			else if (ends_row)
				row_index_q <= row_next;
		end
	end

endmodule

FILE: design/gce_fifo.sv
// Short queue of classified bytes between the front and back parts of the glyph color expander.
// Depends on gce_pkg for its depth and entry type.
module gce_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gce_pkg::job_t push_job,
	input  logic          pop,
	output gce_pkg::job_t head,
	output logic          full,
	output logic          empty
);

	gce_pkg::job_t                 entries_q [gce_pkg::FIFO_DEPTH];
	logic [gce_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [gce_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [gce_pkg::FIFO_PTR_W:0]   fill_q;

	assign full  = (fill_q == (gce_pkg::FIFO_PTR_W+1)'(gce_pkg::FIFO_DEPTH));
	assign empty = (fill_q == '0);
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + (gce_pkg::FIFO_PTR_W)'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + (gce_pkg::FIFO_PTR_W)'(1);
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + (gce_pkg::FIFO_PTR_W+1)'(1);
				2'b01:   fill_q <= fill_q - (gce_pkg::FIFO_PTR_W+1)'(1);
				default: ;
			endcase
		end
	end

endmodule

FILE: design/gce_back.sv
// Back part of the glyph color expander: turns queued bytes into pixel words, one per cycle unless pixel_stall holds.
// Depends on gce_pkg and the assertion macros in glyph_color_expander_core_macros.svh.
`include "glyph_color_expander_core_macros.svh"

module gce_back (
	input  logic          clk,
	input  logic          arst_n,
	input  gce_pkg::cfg_t cfg,
	input  gce_pkg::job_t head,
	input  logic          empty,
	output logic          pop,
	output logic          pixel_valid,
	input  logic          pixel_stall,
	output logic [31:0]   pixel_word,
	output logic          last_of_byte,
	output logic          row_end,
	output logic          glyph_end
);

	gce_pkg::job_t job_q;
	logic          busy_q;
	logic [2:0]    k_q;
	logic          out_valid_q;
	logic [31:0]   word_q;
	logic          last_q;
	logic          row_end_q;
	logic          glyph_end_q;
	logic          emit;
	logic          last;
	logic [31:0]   color;
	logic [3:0]    hi_nib;
	logic [3:0]    lo_nib;
	logic [31:0]   word;

	assign emit = busy_q && (!out_valid_q || !pixel_stall);
	assign last = (({1'b0, k_q} + 4'd1) == job_q.count);
	assign pop  = !empty && (!busy_q || (emit && last));

	always_comb begin
		color  = job_q.data[3'd7 - k_q] ? cfg.ink_color : cfg.paper_color;
		hi_nib = job_q.data[{~k_q[1:0], 1'b1}] ? cfg.ink_color[3:0] : cfg.paper_color[3:0];
		lo_nib = job_q.data[{~k_q[1:0], 1'b0}] ? cfg.ink_color[3:0] : cfg.paper_color[3:0];
		unique case (cfg.depth_mode)
			gce_pkg::DEPTH_4BPP:  word = {24'd0, hi_nib, lo_nib};
			gce_pkg::DEPTH_8BPP:  word = {24'd0, color[7:0]};
			gce_pkg::DEPTH_16BPP: word = {16'd0, color[15:0]};
			gce_pkg::DEPTH_32BPP: word = color;
			default:              word = color;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= head;
		if (emit) begin
			word_q      <= word;
			last_q      <= last;
			row_end_q   <= last && job_q.ends_row;
			glyph_end_q <= last && job_q.ends_glyph;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			k_q         <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				k_q    <= 3'd0;
			end else if (emit) begin
				busy_q <= !last;
				k_q    <= k_q + 3'd1;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (!pixel_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign pixel_valid  = out_valid_q;
	assign pixel_word   = word_q;
	assign last_of_byte = last_q;
	assign row_end      = row_end_q;
	assign glyph_end    = glyph_end_q;

	`GCE_ASSERT_IMPL(a_glyph_end_ends_row, out_valid_q && glyph_end_q, row_end_q,
		"A glyph end must also end a row.")
	`GCE_ASSERT_IMPL(a_row_end_ends_byte, out_valid_q && row_end_q, last_q,
		"A row end must come on the last word of a byte.")
	`GCE_ASSERT_IMPL(a_index_in_range, busy_q, ({1'b0, k_q} < job_q.count),
		"The word index has run past the count of its byte.")
	`GCE_ASSERT_NEXT(a_emit_sets_valid, emit, out_valid_q,
		"An emitted word must show up on the output register.")

endmodule
